// File: rtl/csp_pkg.sv
// Package for the color spec parser: shared types, constants and helpers.
// No dependencies.
package csp_pkg;

    localparam int NAME_CHARS_DEFAULT = 8;
    localparam int HEX_SLOTS          = 12;
    localparam logic [3:0] LEN_CAP    = 4'd14;
    localparam int QUEUE_DEPTH        = 2;

    // one ended string, classified by the front part
    typedef struct packed {
        logic        is_hex;
        logic        hex_bad;
        logic [3:0]  total_len;
        logic [47:0] nibbles;
        logic        name_ok;
        logic [3:0]  name_len;
        logic [63:0] name_text;
    } csp_job_t;

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'h10;
            if (c >= 8'h30 && c <= 8'h39) r = {1'b0, c[3:0]};
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                r = {1'b0, c[3:0] + 4'd9};
            return r;
        end
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
    endfunction

endpackage

// File: rtl/csp_front.sv
// Front part: collects bytes of one string, builds a classified job.
// Depends on csp_pkg.
module csp_front
    import csp_pkg::*;
#(
    parameter int NAME_BUFFER_CHARS = NAME_CHARS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     char_code,
    input  logic           last_char,
    input  logic           no_char,
    output logic           job_valid,
    input  logic           job_ready,
    output csp_job_t       job
);
    localparam int NLW = $clog2(NAME_BUFFER_CHARS + 2);
    localparam int NIW = $clog2(NAME_BUFFER_CHARS);
    localparam logic [NLW-1:0] NCAP = NLW'(NAME_BUFFER_CHARS);

    logic [3:0]     total_len_reg, total_len_next;
    logic           hash_reg, hash_next;
    logic           bad_reg, bad_next;
    logic [3:0]     nib_reg [HEX_SLOTS];
    logic [7:0]     name_reg [NAME_BUFFER_CHARS];
    logic [NLW-1:0] name_len_reg, name_len_next;
    logic           take;
    logic           byte_in;
    logic [4:0]     nib;
    logic [7:0]     lc;
    logic           nib_we, name_we;

    assign in_ready = job_ready;
    assign take     = in_valid && in_ready;
    assign byte_in  = take && !no_char;
    assign nib      = nibble_of(char_code);
    assign lc       = (char_code >= 8'h41 && char_code <= 8'h5a) ? char_code + 8'd32 : char_code;
    assign nib_we   = byte_in && total_len_reg >= 4'd1 && total_len_reg <= 4'd12;
    assign name_we  = byte_in && !is_space(char_code) && name_len_reg < NCAP;

    // control state update; all control state clears after the last byte
    always_comb
    begin
        total_len_next = total_len_reg;
        hash_next      = hash_reg;
        bad_next       = bad_reg;
        name_len_next  = name_len_reg;
        if (byte_in)
        begin
            if (total_len_reg == 4'd0 && char_code == 8'h23) hash_next = 1'b1;
            if (nib_we && nib[4]) bad_next = 1'b1;
            if (total_len_reg < LEN_CAP) total_len_next = total_len_reg + 4'd1;
            if (!is_space(char_code) && name_len_reg <= NCAP)
                name_len_next = name_len_reg + NLW'(1);
        end
        if (take && last_char)
        begin
            total_len_next = '0;
            hash_next      = 1'b0;
            bad_next       = 1'b0;
            name_len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_len_reg <= '0;
            hash_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            name_len_reg  <= '0;
        end
        else
        begin
            total_len_reg <= total_len_next;
            hash_reg      <= hash_next;
            bad_reg       <= bad_next;
            name_len_reg  <= name_len_next;
        end
    end

    // character stores
    always_ff @(posedge clk)
    begin
        if (nib_we) nib_reg[total_len_reg - 4'd1] <= nib[3:0];
        if (name_we) name_reg[name_len_reg[NIW-1:0]] <= lc;
    end

    // job built from the state plus the ending byte
    always_comb
    begin
        logic [3:0] nb [HEX_SLOTS];
        logic [7:0] nm [NAME_BUFFER_CHARS];
        nb = nib_reg;
        nm = name_reg;
        if (nib_we) nb[total_len_reg - 4'd1] = nib[3:0];
        if (name_we) nm[name_len_reg[NIW-1:0]] = lc;
        job.total_len = total_len_reg;
        job.hex_bad   = bad_reg;
        if (byte_in)
        begin
            job.total_len = (total_len_reg < LEN_CAP) ? total_len_reg + 4'd1 : total_len_reg;
            job.hex_bad   = bad_reg || (nib_we && nib[4]);
        end
        job.is_hex = (hash_reg || (byte_in && total_len_reg == 4'd0 && char_code == 8'h23))
                     && (job.total_len == 4'd4 || job.total_len == 4'd7
                         || job.total_len == 4'd13);
        for (int i = 0; i < HEX_SLOTS; i++) job.nibbles[4*i +: 4] = nb[i];
        job.name_len  = '0;
        job.name_ok   = 1'b0;
        job.name_text = '0;
        begin
            logic [NLW-1:0] nl;
            nl = (name_we || (byte_in && !is_space(char_code) && name_len_reg <= NCAP))
                 ? name_len_reg + NLW'(1) : name_len_reg;
            job.name_ok = nl <= NCAP && nl != '0;
            job.name_len = 4'(nl);
            for (int i = 0; i < 8; i++)
                if (i < NAME_BUFFER_CHARS && NLW'(i) < nl) job.name_text[8*i +: 8] = nm[i];
        end
    end

    assign job_valid = take && last_char;
endmodule

// File: rtl/csp_queue.sv
// Two-entry queue between front and back parts.
// Depends on csp_pkg.
module csp_queue
    import csp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  csp_job_t wr_data,
    output logic     rd_valid,
    input  logic     rd_ready,
    output csp_job_t rd_data
);
    csp_job_t   mem_reg [QUEUE_DEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 2'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule

// File: rtl/csp_back.sv
// Back part: hex expansion and name match into a registered result.
// Depends on csp_pkg.
module csp_back
    import csp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  csp_job_t    job,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue
);
    logic        valid_reg;
    logic        found_reg;
    logic [15:0] r_reg, g_reg, b_reg;
    logic        f_c;
    logic [15:0] r_c, g_c, b_c;

    function automatic logic [15:0] comp(input logic [47:0] n, input int first, input int d);
        logic [15:0] v;
        begin
            v = '0;
            if (d == 1) v = {4{n[4*first +: 4]}};
            else if (d == 2) v = {2{n[4*first +: 4], n[4*first+4 +: 4]}};
            else v = {n[4*first +: 4], n[4*first+4 +: 4], n[4*first+8 +: 4], n[4*first+12 +: 4]};
            return v;
        end
    endfunction

    function automatic logic [63:0] str(input string s);
        logic [63:0] v;
        begin
            v = '0;
            for (int i = 0; i < 8; i++) if (i < s.len()) v[8*i +: 8] = s[i];
            return v;
        end
    endfunction

    // name text tagged with its length
    function automatic logic [67:0] key(input string s);
        return {4'(s.len()), str(s)};
    endfunction

    // result selection
    always_comb
    begin
        logic [63:0] t;
        logic [67:0] k;
        f_c = 1'b0; r_c = '0; g_c = '0; b_c = '0;
        t = job.name_text;
        k = '0;
        if (job.is_hex)
        begin
            if (!job.hex_bad)
            begin
                f_c = 1'b1;
                case (job.total_len)
                    4'd4:    begin r_c = comp(job.nibbles,0,1); g_c = comp(job.nibbles,1,1);
                                   b_c = comp(job.nibbles,2,1); end
                    4'd7:    begin r_c = comp(job.nibbles,0,2); g_c = comp(job.nibbles,2,2);
                                   b_c = comp(job.nibbles,4,2); end
                    default: begin r_c = comp(job.nibbles,0,4); g_c = comp(job.nibbles,4,4);
                                   b_c = comp(job.nibbles,8,4); end
                endcase
            end
        end
        else if (job.name_ok)
        begin
            if (t == str("grey")) t = str("gray");
            k = {job.name_len, t};
            f_c = 1'b1;
            if (k == key("black"))        {r_c,g_c,b_c} = {16'h0000,16'h0000,16'h0000};
            else if (k == key("silver"))  {r_c,g_c,b_c} = {16'hc0c0,16'hc0c0,16'hc0c0};
            else if (k == key("gray"))    {r_c,g_c,b_c} = {16'h8080,16'h8080,16'h8080};
            else if (k == key("white"))   {r_c,g_c,b_c} = {16'hffff,16'hffff,16'hffff};
            else if (k == key("maroon"))  {r_c,g_c,b_c} = {16'h8080,16'h0000,16'h0000};
            else if (k == key("red"))     {r_c,g_c,b_c} = {16'hffff,16'h0000,16'h0000};
            else if (k == key("purple"))  {r_c,g_c,b_c} = {16'h8080,16'h0000,16'h8080};
            else if (k == key("fuchsia")) {r_c,g_c,b_c} = {16'hffff,16'h0000,16'hffff};
            else if (k == key("green"))   {r_c,g_c,b_c} = {16'h0000,16'h8080,16'h0000};
            else if (k == key("lime"))    {r_c,g_c,b_c} = {16'h0000,16'hffff,16'h0000};
            else if (k == key("olive"))   {r_c,g_c,b_c} = {16'h8080,16'h8080,16'h0000};
            else if (k == key("yellow"))  {r_c,g_c,b_c} = {16'hffff,16'hffff,16'h0000};
            else if (k == key("navy"))    {r_c,g_c,b_c} = {16'h0000,16'h0000,16'h8080};
            else if (k == key("blue"))    {r_c,g_c,b_c} = {16'h0000,16'h0000,16'hffff};
            else if (k == key("teal"))    {r_c,g_c,b_c} = {16'h0000,16'h8080,16'h8080};
            else if (k == key("aqua"))    {r_c,g_c,b_c} = {16'h0000,16'hffff,16'hffff};
            else f_c = 1'b0;
        end
    end

    assign job_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (job_ready) valid_reg <= job_valid;
    end

    always_ff @(posedge clk)
    begin
        if (job_ready && job_valid)
        begin
            found_reg <= f_c; r_reg <= r_c; g_reg <= g_c; b_reg <= b_c;
        end
    end

    assign out_valid = valid_reg;
    assign found = found_reg;
    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;
endmodule

// File: rtl/color_spec_parser.sv
// Color specification parser, top level: front, queue and back parts.
// Channels: in (char_code, last_char, no_char) and out (found, red, green, blue),
// both valid/ready. One byte is taken every cycle while the queue has room.
// The transfer carrying last_char enqueues a job, held in a queue entry and then
// in the back part's output register, which drives out_valid. Throughput is one
// character per cycle while the queue has room, set by the per-byte front update.
// A stalled receiver holds the output register; the two-entry queue fills
// and then in_ready drops until the receiver takes the result.
// Reset clears all counts and flags; no clearing pass is needed.
// Depends on csp_pkg, csp_front, csp_queue, csp_back.
module color_spec_parser
    import csp_pkg::*;
#(
    parameter int NAME_BUFFER_CHARS = NAME_CHARS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic        no_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] red,
    output logic [15:0] green,
    output logic [15:0] blue
);
    logic     fq_valid, fq_ready, qb_valid, qb_ready;
    csp_job_t fq_job, qb_job;

    csp_front #(.NAME_BUFFER_CHARS(NAME_BUFFER_CHARS)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .char_code, .last_char, .no_char,
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    csp_queue u_queue (
        .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_job)
    );

    csp_back u_back (
        .clk, .rst_n, .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
        .out_valid, .out_ready, .found, .red, .green, .blue
    );
endmodule

// File: rtl/csp_checker.sv
// Port-level checker for the color spec parser, bound to the top level.
// Depends on nothing but the top level's ports.
module csp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        found,
    input logic [15:0] red,
    input logic [15:0] green,
    input logic [15:0] blue
);
    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({found, red, green, blue}))
        else $error("stalled result changed");

    // not found means all components zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> red == 16'h0 && green == 16'h0 && blue == 16'h0)
        else $error("nonzero color on not found");

    // after reset no result is shown
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result during reset");
endmodule

bind color_spec_parser csp_checker u_csp_checker (.*);
